[sv/undo_history_ring_unit_assert.svh]
// Assertion macros used by the port checker of the undo history ring unit.
// Needs a clock named clk and an active-high reset named rst in the scope of use.
`ifndef UNDO_HISTORY_RING_UNIT_ASSERT_SVH
`define UNDO_HISTORY_RING_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/uhr_pkg.sv]
// Shared types, codes and default sizes for the undo history ring unit.
// No dependencies; used by the memories, the top level and the checker.
package uhr_pkg;

  // Default sizes.
  localparam int HISTORY_DEPTH_DEF = 256;
  localparam int BASE_SLOTS_DEF    = 64;

  // Action codes.
  localparam logic [2:0] ACT_RECORD = 3'd0;
  localparam logic [2:0] ACT_UNDO   = 3'd1;
  localparam logic [2:0] ACT_REDO   = 3'd2;
  localparam logic [2:0] ACT_ADD    = 3'd3;
  localparam logic [2:0] ACT_REMOVE = 3'd4;

  // Change kinds.
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_MOVE   = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  // Effect codes.
  localparam logic [2:0] EFF_NONE    = 3'd0;
  localparam logic [2:0] EFF_HIDE    = 3'd1;
  localparam logic [2:0] EFF_RESTORE = 3'd2;
  localparam logic [2:0] EFF_SETPOS  = 3'd3;
  localparam logic [2:0] EFF_MISSING = 3'd4;

  // One change record in the history ring.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] obj;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } ring_entry_t;

  // One base position record.
  typedef struct packed {
    logic [31:0] obj;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } base_entry_t;

endpackage

[sv/undo_history_ring_unit.sv]
// Undo history ring unit: sequencer around the ring and base table memories (uhr_pkg,
// uhr_ring_mem, uhr_base_mem). Record and ignored items go straight to output; redo and
// undo of create or delete read one ring entry; undo of a move walks the ring back to the
// tail, then the base table if no match, one entry a cycle; base add or remove walks the
// base slots. One item at a time: input is ready in the cycle after the result loads (a
// stalled output delays it). Reset clears pointers and base valid bits; no clearing pass.
module undo_history_ring_unit #(
  parameter int HISTORY_DEPTH = uhr_pkg::HISTORY_DEPTH_DEF,
  parameter int BASE_SLOTS    = uhr_pkg::BASE_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // object, pos_x, pos_y, pos_z
  input  logic [4:0]   s_tuser,  // action, change_kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,  // effect_object, new_x, new_y, new_z, at_start, at_end,
                                 // base_full, zero fill
  output logic [2:0]   m_tuser   // effect
);

  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int BW = (BASE_SLOTS > 1) ? $clog2(BASE_SLOTS) : 1;
  localparam logic [HW-1:0] H_LAST = HW'(HISTORY_DEPTH - 1);
  localparam logic [BW-1:0] B_LAST = BW'(BASE_SLOTS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RING  = 7'b0000010,
    S_RSCAN = 7'b0000100,
    S_BSCAN = 7'b0001000,
    S_BADD  = 7'b0010000,
    S_BREM  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [HW-1:0] head, tail, cursor, scan_idx;
  logic [BW-1:0] slot;
  logic [BASE_SLOTS-1:0] base_valid;

  // Captured item.
  logic [2:0]  act_q;
  logic [31:0] obj_q, px_q, py_q, pz_q;

  // Result being built.
  logic [2:0]  res_eff;
  logic [31:0] res_obj, res_x, res_y, res_z;
  logic        res_full;

  function automatic logic [HW-1:0] ptr_inc(input logic [HW-1:0] p);
    return (p == H_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [HW-1:0] ptr_dec(input logic [HW-1:0] p);
    return (p == '0) ? H_LAST : p - 1'b1;
  endfunction

  function automatic logic in_live(input logic [HW-1:0] x, input logic [HW-1:0] first,
                                   input logic [HW-1:0] second);
    if (second > first) return (x >= first) && (x <= second);
    return (x >= first) || (x <= second);
  endfunction

  // Input item fields.
  logic [2:0]  in_act;
  logic [1:0]  in_kind;
  logic        accept;
  assign in_act   = s_tuser[2:0];
  assign in_kind  = s_tuser[4:3];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Cursor step helpers for the current pointers.
  logic [HW-1:0] cur_back, cur_fwd;
  logic          back_ok, fwd_ok, rec_ok, undo_ok, redo_ok;
  assign cur_back = ptr_dec(cursor);
  assign cur_fwd  = ptr_inc(cursor);
  assign back_ok  = in_live(cur_back, tail, head);
  assign fwd_ok   = in_live(cur_fwd, tail, head);
  assign rec_ok   = (in_act == uhr_pkg::ACT_RECORD) && (in_kind != uhr_pkg::KIND_BAD);
  assign undo_ok  = (in_act == uhr_pkg::ACT_UNDO) && (cursor != tail) && (head != tail);
  assign redo_ok  = (in_act == uhr_pkg::ACT_REDO) && (cursor != head);

  // Ring memory.
  logic                 ring_we;
  uhr_pkg::ring_entry_t ring_wdata, ring_rdata;
  logic [HW-1:0]        ring_raddr;

  assign ring_we    = accept && rec_ok;
  assign ring_wdata = '{kind: in_kind, obj: s_tdata[31:0], px: s_tdata[63:32],
                        py: s_tdata[95:64], pz: s_tdata[127:96]};

  // Ring read address: the entry needed in the next cycle.
  always_comb begin
    unique case (state) inside
      S_IDLE:          ring_raddr = (in_act == uhr_pkg::ACT_UNDO && back_ok) ? cur_back
                                                                           : cursor;
      S_RING, S_RSCAN: ring_raddr = ptr_dec(scan_idx);
      default:         ring_raddr = scan_idx;
    endcase
  end

  uhr_ring_mem #(.DEPTH(HISTORY_DEPTH), .AW(HW)) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (cursor),
    .wr_data (ring_wdata),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  // Base memory.
  logic                 base_we;
  uhr_pkg::base_entry_t base_wdata, base_rdata;
  logic [BW-1:0]        base_raddr;
  logic                 slot_hit;

  assign base_we    = (state == S_BADD) && !base_valid[slot];
  assign base_wdata = '{obj: obj_q, px: px_q, py: py_q, pz: pz_q};
  assign base_raddr = (state == S_BSCAN || state == S_BREM) ? BW'(slot + 1'b1) : '0;
  assign slot_hit   = base_valid[slot] && (base_rdata.obj == res_obj);

  uhr_base_mem #(.DEPTH(BASE_SLOTS), .AW(BW)) u_base (
    .clk     (clk),
    .wr_en   (base_we),
    .wr_addr (slot),
    .wr_data (base_wdata),
    .rd_addr (base_raddr),
    .rd_data (base_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      cursor     <= '0;
      base_valid <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // A taken result clears valid unless a new one is loaded in the same cycle.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act_q    <= in_act;
            obj_q    <= s_tdata[31:0];
            px_q     <= s_tdata[63:32];
            py_q     <= s_tdata[95:64];
            pz_q     <= s_tdata[127:96];
            res_eff  <= uhr_pkg::EFF_NONE;
            res_obj  <= s_tdata[31:0];
            res_x    <= '0;
            res_y    <= '0;
            res_z    <= '0;
            res_full <= 1'b0;
            slot     <= '0;
            scan_idx <= ring_raddr;
            state    <= S_OUT;
            if (rec_ok) begin
              head   <= cur_fwd;
              cursor <= cur_fwd;
              if (cur_fwd == tail) begin
                tail <= ptr_inc(tail);
              end
            end else if (undo_ok) begin
              if (back_ok) cursor <= cur_back;
              state <= S_RING;
            end else if (redo_ok) begin
              if (fwd_ok) cursor <= cur_fwd;
              state <= S_RING;
            end else if (in_act == uhr_pkg::ACT_ADD) begin
              state <= S_BADD;
            end else if (in_act == uhr_pkg::ACT_REMOVE) begin
              state <= S_BREM;
            end
          end
        end

        // Entry to undo or redo is in ring_rdata.
        S_RING: begin
          res_obj <= ring_rdata.obj;
          state   <= S_OUT;
          unique case (ring_rdata.kind)
            uhr_pkg::KIND_CREATE:
              res_eff <= (act_q == uhr_pkg::ACT_UNDO) ? uhr_pkg::EFF_HIDE
                                                       : uhr_pkg::EFF_RESTORE;
            uhr_pkg::KIND_DELETE:
              res_eff <= (act_q == uhr_pkg::ACT_UNDO) ? uhr_pkg::EFF_RESTORE
                                                       : uhr_pkg::EFF_HIDE;
            uhr_pkg::KIND_MOVE: begin
              if (act_q == uhr_pkg::ACT_UNDO) begin
                if (scan_idx != tail) begin
                  scan_idx <= ptr_dec(scan_idx);
                  state    <= S_RSCAN;
                end else begin
                  state <= S_BSCAN;
                end
              end else begin
                res_eff <= uhr_pkg::EFF_SETPOS;
                res_x   <= ring_rdata.px;
                res_y   <= ring_rdata.py;
                res_z   <= ring_rdata.pz;
              end
            end
            default: res_obj <= '0;
          endcase
        end

        // Walk back toward the tail for an earlier move of the same object.
        S_RSCAN: begin
          if (ring_rdata.kind == uhr_pkg::KIND_MOVE && ring_rdata.obj == res_obj) begin
            res_eff <= uhr_pkg::EFF_SETPOS;
            res_x   <= ring_rdata.px;
            res_y   <= ring_rdata.py;
            res_z   <= ring_rdata.pz;
            state   <= S_OUT;
          end else if (scan_idx == tail) begin
            state <= S_BSCAN;
          end else begin
            scan_idx <= ptr_dec(scan_idx);
          end
        end

        // Lowest matching base slot supplies the position.
        S_BSCAN: begin
          if (slot_hit) begin
            res_eff <= uhr_pkg::EFF_SETPOS;
            res_x   <= base_rdata.px;
            res_y   <= base_rdata.py;
            res_z   <= base_rdata.pz;
            state   <= S_OUT;
          end else if (slot == B_LAST) begin
            res_eff <= uhr_pkg::EFF_MISSING;
            state   <= S_OUT;
          end else begin
            slot <= BW'(slot + 1'b1);
          end
        end

        // Lowest free slot takes the new base state.
        S_BADD: begin
          res_obj <= '0;
          if (!base_valid[slot]) begin
            base_valid[slot] <= 1'b1;
            state            <= S_OUT;
          end else if (slot == B_LAST) begin
            res_full <= 1'b1;
            state    <= S_OUT;
          end else begin
            slot <= BW'(slot + 1'b1);
          end
        end

        // Lowest matching slot is released; the object to match stays in res_obj.
        S_BREM: begin
          if (slot_hit) begin
            base_valid[slot] <= 1'b0;
            state            <= S_OUT;
          end else if (slot == B_LAST) begin
            state <= S_OUT;
          end else begin
            slot <= BW'(slot + 1'b1);
          end
        end

        // Load the output register once it is free.
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_eff;
            m_tdata  <= {5'b0, res_full, (cursor == head), (cursor == tail),
                         res_z, res_y, res_x,
                         (res_eff == uhr_pkg::EFF_NONE) ? 32'd0 : res_obj};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/uhr_ring_mem.sv]
// History ring storage: one write port, one read port with registered data.
// Depends on uhr_pkg for the entry type.
module uhr_ring_mem #(
  parameter int DEPTH = uhr_pkg::HISTORY_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  uhr_pkg::ring_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output uhr_pkg::ring_entry_t rd_data
);

  uhr_pkg::ring_entry_t mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/uhr_base_mem.sv]
// Base position table storage: one write port, one read port with registered data.
// Depends on uhr_pkg for the entry type.
module uhr_base_mem #(
  parameter int DEPTH = uhr_pkg::BASE_SLOTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  uhr_pkg::base_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output uhr_pkg::base_entry_t rd_data
);

  uhr_pkg::base_entry_t mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/uhr_checker.sv]
// Port-level checker for the undo history ring unit, bound to the top level.
// Depends on undo_history_ring_unit_assert.svh, uhr_pkg and the top level's port list.
`include "undo_history_ring_unit_assert.svh"

module uhr_port_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic [2:0]   m_tuser
);

  logic         s_xfer, out_stall, out_full, out_none;
  logic [138:0] out_word;

  assign s_xfer    = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;
  assign out_word  = {m_tuser, m_tdata};
  assign out_full  = m_tvalid && m_tdata[130];
  assign out_none  = m_tvalid && (m_tuser == uhr_pkg::EFF_NONE);

  // A stalled result holds.
  `UHR_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "stalled result changed")

  // One item in work at a time: no input transfer right after another.
  `UHR_ASSERT_NEXT(a_one_item, s_xfer, !s_tready, "input taken while busy")

  // A full base table gives no other effect.
  `UHR_ASSERT_NOW(a_full_none, out_full, m_tuser == uhr_pkg::EFF_NONE, "full flag with an effect")

  // An effect of none carries no object or position.
  `UHR_ASSERT_NOW(a_none_clean, out_none, m_tdata[127:0] == '0, "idle effect carries data")

endmodule

bind undo_history_ring_unit uhr_port_checker u_uhr_port_checker (.*);
